>>> rtl/jdc_pkg.sv
// jdc_pkg: shared widths, register codes and stage payload types
// for the joystick to drive command pipeline; no dependencies
`default_nettype none

package jdc_pkg;

    localparam int AXIS_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 7;
    localparam int TOP_W     = 16;
    localparam int PROD_W    = TOP_W + CNT_W;
    localparam int QUO_W     = 16;
    localparam int SPEED_W   = 17;
    localparam int DIV_STEP  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [BYTE_W-1:0] NEUTRAL_BYTE  = 8'd128;
    localparam logic [TOP_W-1:0]  TOP_SPEED_RST = 16'd256;

    typedef enum logic [1:0] {
        CTRL_WHEEL     = 2'd0,
        CTRL_PAD_TRIG  = 2'd1,
        CTRL_PAD_STICK = 2'd2,
        CTRL_NEUTRAL   = 2'd3
    } ctrl_type_t;

    typedef enum logic [1:0] {
        REG_CTRL_TYPE    = 2'd0,
        REG_STEER_OFFSET = 2'd1,
        REG_DEADBAND     = 2'd2,
        REG_TOP_SPEED    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        ctrl_type_t              ctrl_type;
        logic signed [BYTE_W-1:0] steer_offset;
        logic [CNT_W-1:0]        deadband;
        logic [TOP_W-1:0]        top_speed;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] thr;
        logic [BYTE_W-1:0] steering;
    } map_out_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic              neg;
        logic              nz;
        logic [BYTE_W-1:0] steering;
    } scale_out_t;

    typedef struct packed {
        logic [PROD_W-1:0] num;
        logic [CNT_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              nz;
        logic [BYTE_W-1:0] steering;
    } div_stage_t;

endpackage

`default_nettype wire

>>> rtl/jdc_map.sv
// jdc_map: first pipeline stage, axis to throttle byte and steering byte
// depends on jdc_pkg
`default_nettype none

module jdc_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jdc_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_0,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_1,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_2,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_3,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_5,
    output logic                               out_valid,
    input  logic                               out_stall,
    output jdc_pkg::map_out_t                  out_data
);
    import jdc_pkg::*;

    // offset by 32768 and keep the top byte
    function automatic logic [BYTE_W-1:0] axis_byte(input logic [AXIS_W-1:0] a);
        return {~a[AXIS_W-1], a[AXIS_W-2:AXIS_W-BYTE_W]};
    endfunction

    // half the pedal difference, toward zero, then floor to a byte around 128
    function automatic logic [BYTE_W-1:0] pedal(input logic [AXIS_W-1:0] gas,
                                                input logic [AXIS_W-1:0] brake);
        logic signed [AXIS_W:0] diff;
        logic signed [AXIS_W:0] adj;
        logic signed [AXIS_W:0] half;
        diff = $signed({1'b0, ~gas[AXIS_W-1], gas[AXIS_W-2:0]})
             - $signed({1'b0, ~brake[AXIS_W-1], brake[AXIS_W-2:0]});
        adj  = diff + $signed({{AXIS_W{1'b0}}, diff[AXIS_W]});
        half = adj >>> 1;
        return {~half[AXIS_W-1], half[AXIS_W-2:AXIS_W-BYTE_W]};
    endfunction

    // inverted stick, full deflection saturates at 255
    function automatic logic [BYTE_W-1:0] stick(input logic [AXIS_W-1:0] a);
        logic [AXIS_W:0] v;
        v = (AXIS_W+1)'(32768) - {a[AXIS_W-1], a};
        return v[AXIS_W] ? {BYTE_W{1'b1}} : v[AXIS_W-1:AXIS_W-BYTE_W];
    endfunction

    logic [BYTE_W-1:0]   thr;
    logic [BYTE_W-1:0]   steer;
    logic signed [BYTE_W+1:0] steer_sum;
    logic [BYTE_W-1:0]   steer_clamp;
    map_out_t            data_next;
    logic                valid_reg;
    map_out_t            data_reg;
    logic                advance;

    always_comb
    begin
        case (cfg.ctrl_type)
            CTRL_WHEEL:
            begin
                thr   = pedal(axis_2, axis_1);
                steer = axis_byte(axis_0);
            end
            CTRL_PAD_TRIG:
            begin
                thr   = pedal(axis_5, axis_2);
                steer = axis_byte(axis_3);
            end
            CTRL_PAD_STICK:
            begin
                thr   = stick(axis_1);
                steer = axis_byte(axis_3);
            end
            default:
            begin
                thr   = NEUTRAL_BYTE;
                steer = NEUTRAL_BYTE;
            end
        endcase

        steer_sum = $signed({2'b00, steer})
                  + $signed({{2{cfg.steer_offset[BYTE_W-1]}}, cfg.steer_offset});
        if (steer_sum < 0)
            steer_clamp = '0;
        else if (steer_sum > $signed((BYTE_W+2)'(255)))
            steer_clamp = {BYTE_W{1'b1}};
        else
            steer_clamp = steer_sum[BYTE_W-1:0];

        data_next.thr      = thr;
        data_next.steering = ~steer_clamp;    // 255 minus clamped value
    end

    assign in_stall  = valid_reg && out_stall;
    assign advance   = !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

>>> rtl/jdc_scale.sv
// jdc_scale: second pipeline stage, deadband and top speed product
// depends on jdc_pkg
`default_nettype none

module jdc_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jdc_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jdc_pkg::map_out_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jdc_pkg::scale_out_t  out_data
);
    import jdc_pkg::*;

    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_adj;
    logic             nz;
    scale_out_t       data_next;
    scale_out_t       data_reg;
    logic             valid_reg;
    logic             advance;

    always_comb
    begin
        // distance from center: at or above 128 it is thr-128, else 127-thr
        count     = in_data.thr[BYTE_W-1] ? in_data.thr[CNT_W-1:0] : ~in_data.thr[CNT_W-1:0];
        nz        = count > cfg.deadband;
        count_adj = nz ? CNT_W'(count - cfg.deadband) : '0;

        data_next.product  = {{CNT_W{1'b0}}, cfg.top_speed} * {{TOP_W{1'b0}}, count_adj};
        data_next.neg      = ~in_data.thr[BYTE_W-1];
        data_next.nz       = nz;
        data_next.steering = in_data.steering;
    end

    assign in_stall  = valid_reg && out_stall;
    assign advance   = !in_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

    a_zero_count_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.nz |-> data_reg.product == '0)
        else $error("product nonzero for a suppressed throttle count");

endmodule

`default_nettype wire

>>> rtl/jdc_divider.sv
// jdc_divider: pipelined restoring divider, product / (127 - deadband),
// a few quotient bits per stage, then sign; depends on jdc_pkg
`default_nettype none

module jdc_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jdc_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jdc_pkg::scale_out_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [jdc_pkg::SPEED_W-1:0]  speed,
    output logic [jdc_pkg::BYTE_W-1:0]          steering
);
    import jdc_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [CNT_W-1:0]    divisor;
    div_stage_t          stg_init;
    div_stage_t          stg_in    [DIV_STAGES];
    div_stage_t          stg_next  [DIV_STAGES];
    div_stage_t          stg_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_in;
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] stall_at;
    logic [QUO_W-1:0]    mag;

    // 127 - deadband in seven bits
    assign divisor = ~cfg.deadband;

    always_comb
    begin
        stg_init.num      = in_data.product;
        stg_init.rem      = in_data.product[PROD_W-1:QUO_W];
        stg_init.quo      = '0;
        stg_init.neg      = in_data.neg;
        stg_init.nz       = in_data.nz;
        stg_init.steering = in_data.steering;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int BASE = QUO_W - 1 - k * DIV_STEP;

        if (k == 0)
        begin : g_first
            assign stg_in[k]   = stg_init;
            assign valid_in[k] = in_valid;
        end
        else
        begin : g_next
            assign stg_in[k]   = stg_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        if (k == LAST)
        begin : g_tail
            assign stall_at[k] = valid_reg[k] && out_stall;
        end
        else
        begin : g_body
            assign stall_at[k] = valid_reg[k] && stall_at[k+1];
        end

        always_comb
        begin
            div_stage_t        s;
            logic [CNT_W:0]    trial;
            s = stg_in[k];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                trial = {s.rem, s.num[BASE - j]};
                if (trial >= {1'b0, divisor})
                begin
                    s.rem          = CNT_W'(trial - {1'b0, divisor});
                    s.quo[BASE - j] = 1'b1;
                end
                else
                begin
                    s.rem = trial[CNT_W-1:0];
                end
            end
            stg_next[k] = s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (!stall_at[k])
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (!stall_at[k] && valid_in[k])
                stg_reg[k] <= stg_next[k];
        end
    end

    assign in_stall  = stall_at[0];
    assign out_valid = valid_reg[LAST];

    // zero count forces zero, which also covers a zero divisor
    assign mag      = stg_reg[LAST].nz ? stg_reg[LAST].quo : '0;
    assign speed    = stg_reg[LAST].neg ? $signed(SPEED_W'(0) - {1'b0, mag})
                                        : $signed({1'b0, mag});
    assign steering = stg_reg[LAST].steering;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_check
        localparam int BASE = QUO_W - 1 - k * DIV_STEP;

        a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg[k] && stall_at[k] |=> valid_reg[k] && $stable(stg_reg[k]))
            else $error("divider stage changed while stalled");

        if (k < LAST)
        begin : g_low
            a_low_quotient_clear: assert property (@(posedge clk) disable iff (!rst_n)
                valid_reg[k] |-> stg_reg[k].quo[BASE-DIV_STEP:0] == '0)
                else $error("quotient bits set ahead of their stage");
        end
    end

endmodule

`default_nettype wire

>>> rtl/joystick_to_drive_command_top.sv
// joystick_to_drive_command_top: configuration registers and the
// map, scale and divider pipeline; depends on jdc_pkg, jdc_map, jdc_scale, jdc_divider
`default_nettype none

// Maps one joystick sample (five axes) to a signed Q9.8 speed and an 8-bit
// steering command. One sample can be taken every clock cycle unless
// in_stall is high. Each sample passes through the stages in order: one
// stage maps the axes to a throttle byte and a trimmed, clamped steering
// byte, one stage applies the deadband and multiplies by top_speed, and
// four stages of a restoring divider produce four quotient bits each of
// top_speed * count / (127 - deadband). The output sits in the last divider
// register, so a stall on the output holds that register and fills the
// pipeline behind it; in_stall rises only once every stage holds a sample.
// Registers sit on an APB-style port at byte addresses 0 (controller_type),
// 4 (steering_offset), 8 (deadband) and 12 (top_speed); write them only
// while no transfer is in flight. There is no memory and no start-up sweep.
module joystick_to_drive_command_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jdc_pkg::ADDR_W-1:0]         paddr,
    input  logic [jdc_pkg::DATA_W-1:0]         pwdata,
    output logic [jdc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // sample input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_0,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_1,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_2,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_3,
    input  logic signed [jdc_pkg::AXIS_W-1:0]  axis_5,
    // drive command output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [jdc_pkg::SPEED_W-1:0] speed,
    output logic [jdc_pkg::BYTE_W-1:0]         steering
);
    import jdc_pkg::*;

    cfg_t       cfg_reg;
    reg_idx_t   reg_sel;
    logic       cfg_write;

    logic       map_valid;
    logic       map_stall;
    map_out_t   map_data;
    logic       scale_valid;
    logic       scale_stall;
    scale_out_t scale_data;

    // register index from the word address
    assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ctrl_type    <= CTRL_WHEEL;
            cfg_reg.steer_offset <= '0;
            cfg_reg.deadband     <= '0;
            cfg_reg.top_speed    <= TOP_SPEED_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_CTRL_TYPE:    cfg_reg.ctrl_type    <= ctrl_type_t'(pwdata[1:0]);
                REG_STEER_OFFSET: cfg_reg.steer_offset <= $signed(pwdata[BYTE_W-1:0]);
                REG_DEADBAND:     cfg_reg.deadband     <= pwdata[CNT_W-1:0];
                REG_TOP_SPEED:    cfg_reg.top_speed    <= pwdata[TOP_W-1:0];
                default:          ;
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (reg_sel)
            REG_CTRL_TYPE:    prdata = DATA_W'(cfg_reg.ctrl_type);
            REG_STEER_OFFSET: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_reg.steer_offset};
            REG_DEADBAND:     prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.deadband};
            REG_TOP_SPEED:    prdata = {{(DATA_W-TOP_W){1'b0}}, cfg_reg.top_speed};
            default:          prdata = '0;
        endcase
    end

    // stage 1: axes to throttle and steering bytes
    jdc_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .axis_0    (axis_0),
        .axis_1    (axis_1),
        .axis_2    (axis_2),
        .axis_3    (axis_3),
        .axis_5    (axis_5),
        .out_valid (map_valid),
        .out_stall (map_stall),
        .out_data  (map_data)
    );

    // stage 2: deadband and scale product
    jdc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (map_valid),
        .in_stall  (map_stall),
        .in_data   (map_data),
        .out_valid (scale_valid),
        .out_stall (scale_stall),
        .out_data  (scale_data)
    );

    // stages 3 to 6: division and sign, last stage is the output register
    jdc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (scale_valid),
        .in_stall  (scale_stall),
        .in_data   (scale_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .speed     (speed),
        .steering  (steering)
    );

    // back-pressure only ever originates at a held output transfer
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output transfer");

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for joystick_to_drive_command_top, a directed table
// then random phases, checked against typed answers or a local speed/steering model
// depends on jdc_pkg and the rtl of joystick_to_drive_command_top
`timescale 1ns / 1ps

module tb;

    import jdc_pkg::*;

    localparam int AXIS_OFFSET    = 32768;
    localparam int U16_MAX        = 65535;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_SAMPLES  = 190;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 200000;

    typedef logic signed [AXIS_W-1:0] axis_t;

    // one joystick sample as it goes over the input channel
    typedef struct packed {
        axis_t a0;
        axis_t a1;
        axis_t a2;
        axis_t a3;
        axis_t a5;
    } axis_set_t;

    // one drive command as it comes out of the block
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [BYTE_W-1:0]         steering;
    } drive_cmd_t;

    // directed table row: register setting, sample, and optionally a typed-in answer
    typedef struct {
        cfg_t       cfg;
        axis_set_t  ax;
        bit         typed;
        drive_cmd_t want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    axis_t                      axis_0 = '0;
    axis_t                      axis_1 = '0;
    axis_t                      axis_2 = '0;
    axis_t                      axis_3 = '0;
    axis_t                      axis_5 = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SPEED_W-1:0]  speed;
    logic [BYTE_W-1:0]          steering;

    // model copy of the registers, only touched while the block is idle
    cfg_t        drive_cfg;
    // commands predicted for accepted samples, oldest first
    drive_cmd_t  pending_cmds[$];
    drive_cmd_t  got_cmd;
    stim_row_t   directed_rows[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    bit          long_hold_req = 1'b0;

    joystick_to_drive_command_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .axis_0    (axis_0),
        .axis_1    (axis_1),
        .axis_2    (axis_2),
        .axis_3    (axis_3),
        .axis_5    (axis_5),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .speed     (speed),
        .steering  (steering)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drive command model
    // ------------------------------------------------------------------

    function automatic int clamp_u16(input int v);
        if (v < 0)
            return 0;
        if (v > U16_MAX)
            return U16_MAX;
        return v;
    endfunction

    // throttle byte from a gas axis minus a brake axis, halved toward zero
    function automatic int trigger_throttle(input int gas, input int brake);
        int g;
        int b;
        int d;
        g = clamp_u16(gas + AXIS_OFFSET);
        b = clamp_u16(brake + AXIS_OFFSET);
        d = (g - b) / 2;
        return (d + AXIS_OFFSET) >>> 8;
    endfunction

    function automatic drive_cmd_t predict_command(input axis_set_t ax);
        int         thr;
        int         steer;
        int         count;
        int         db;
        int         mag;
        int         spd;
        int         steer_out;
        bit         reverse;
        drive_cmd_t cmd;
        thr   = NEUTRAL_BYTE;
        steer = NEUTRAL_BYTE;
        case (drive_cfg.ctrl_type)
            CTRL_WHEEL:
            begin
                thr   = trigger_throttle($signed(ax.a2), $signed(ax.a1));
                steer = clamp_u16($signed(ax.a0) + AXIS_OFFSET) >>> 8;
            end
            CTRL_PAD_TRIG:
            begin
                thr   = trigger_throttle($signed(ax.a5), $signed(ax.a2));
                steer = clamp_u16($signed(ax.a3) + AXIS_OFFSET) >>> 8;
            end
            CTRL_PAD_STICK:
            begin
                // stick axis is inverted: full forward is the most negative value
                thr   = clamp_u16(AXIS_OFFSET - $signed(ax.a1)) >>> 8;
                steer = clamp_u16($signed(ax.a3) + AXIS_OFFSET) >>> 8;
            end
            default:
            begin
            end
        endcase

        // trim then clamp steering to a byte
        steer = steer + $signed(drive_cfg.steer_offset);
        if (steer < 0)
            steer = 0;
        else if (steer > 255)
            steer = 255;

        // deadband around center, below center drives backward
        if (thr >= 128)
        begin
            reverse = 1'b0;
            count   = thr - 128;
        end
        else
        begin
            reverse = 1'b1;
            count   = 127 - thr;
        end
        db = drive_cfg.deadband;
        if (count > db)
            count = count - db;
        else
            count = 0;

        // full deadband leaves no divisor, speed is simply zero
        mag = 0;
        if (count != 0 && db < 127)
            mag = (int'(drive_cfg.top_speed) * count) / (127 - db);
        spd = reverse ? -mag : mag;

        steer_out    = 255 - steer;
        cmd.speed    = spd[SPEED_W-1:0];
        cmd.steering = steer_out[BYTE_W-1:0];
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic cfg_t make_cfg(input ctrl_type_t t, input int off, input int db,
                                      input int top);
        cfg_t c;
        c.ctrl_type    = t;
        c.steer_offset = 8'(off);
        c.deadband     = 7'(db);
        c.top_speed    = 16'(top);
        return c;
    endfunction

    // axis values weighted toward the rails and toward center
    function automatic axis_t rand_axis();
        int v;
        case ($urandom_range(0, 7))
            0: v = -AXIS_OFFSET;
            1: v = AXIS_OFFSET - 1;
            2, 3: v = int'($urandom_range(0, 4095)) - 2048;
            default: v = $urandom;
        endcase
        return axis_t'(v);
    endfunction

    task automatic add_row(input ctrl_type_t t, input int off, input int db, input int top,
                           input int a0, input int a1, input int a2, input int a3,
                           input int a5, input bit typed, input int sp, input int st);
        stim_row_t r;
        r.cfg           = make_cfg(t, off, db, top);
        r.ax.a0         = axis_t'(a0);
        r.ax.a1         = axis_t'(a1);
        r.ax.a2         = axis_t'(a2);
        r.ax.a3         = axis_t'(a3);
        r.ax.a5         = axis_t'(a5);
        r.typed         = typed;
        r.want.speed    = SPEED_W'(sp);
        r.want.steering = BYTE_W'(st);
        directed_rows.push_back(r);
    endtask

    // one register write: setup cycle then access cycle
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering samples and wait until every predicted command came out
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_cmds.size() != 0);
        @(negedge clk);
    endtask

    // registers are only written with the pipeline empty
    task automatic apply_cfg(input cfg_t c);
        wait_idle();
        apb_write(REG_CTRL_TYPE, DATA_W'(c.ctrl_type));
        apb_write(REG_STEER_OFFSET, DATA_W'($unsigned(c.steer_offset)));
        apb_write(REG_DEADBAND, DATA_W'(c.deadband));
        apb_write(REG_TOP_SPEED, DATA_W'(c.top_speed));
        drive_cfg = c;
    endtask

    // offer one sample, called at a falling edge, returns at a falling edge;
    // valid is left high so back-to-back transfers need no toggle
    task automatic send_sample(input axis_set_t ax, input drive_cmd_t want);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        axis_0   <= ax.a0;
        axis_1   <= ax.a1;
        axis_2   <= ax.a2;
        axis_3   <= ax.a3;
        axis_5   <= ax.a5;
        // transfer happens at the first rising edge without stall
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_cmds.push_back(want);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                // long hold so the pipeline fills and backs up into in_stall
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4))
                    @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: every output transfer against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_cmds.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer, expected none, actual speed %0d steering %0d",
                         $time, speed, steering);
            end
            else
            begin
                got_cmd = pending_cmds.pop_front();
                if (speed !== got_cmd.speed)
                begin
                    error_count++;
                    $display("%0t: speed mismatch, expected %0d, actual %0d",
                             $time, got_cmd.speed, speed);
                end
                if (steering !== got_cmd.steering)
                begin
                    error_count++;
                    $display("%0t: steering mismatch, expected %0d, actual %0d",
                             $time, got_cmd.steering, steering);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        axis_set_t  ax;
        cfg_t       phase_cfg;
        int         db;
        int         off;
        int         top;

        // directed table
        // type, offset, deadband, top, a0, a1, a2, a3, a5, typed, speed, steering
        // reset setting, everything centered
        add_row(CTRL_WHEEL, 0, 0, 256, 0, 0, 0, 0, 0, 1, 0, 127);
        // wheel: full gas with brake released, and the reverse
        add_row(CTRL_WHEEL, 0, 0, 256, -32768, -32768, 32767, 0, 0, 1, 256, 255);
        add_row(CTRL_WHEEL, 0, 0, 256, 32767, 32767, -32768, 0, 0, 1, -256, 0);
        // just below and just above the center byte
        add_row(CTRL_WHEEL, 0, 0, 256, 100, 0, -2, 0, 0, 0, 0, 0);
        add_row(CTRL_WHEEL, 0, 0, 256, -100, -512, 0, 0, 0, 0, 0, 0);
        // pad triggers: gas on axis 5, brake on axis 2, steering on axis 3
        add_row(CTRL_PAD_TRIG, 0, 0, 256, 32767, 0, -32768, -32768, 32767, 1, 256, 255);
        add_row(CTRL_PAD_TRIG, 0, 0, 256, -32768, 0, 32767, 32767, -32768, 1, -256, 0);
        // pad stick: most negative stick value is full throttle
        add_row(CTRL_PAD_STICK, 0, 0, 256, 0, -32768, 0, 0, 0, 1, 256, 127);
        add_row(CTRL_PAD_STICK, 0, 0, 256, 0, 32767, 0, 32767, 0, 1, -256, 0);
        add_row(CTRL_PAD_STICK, 0, 0, 256, 0, 0, 0, -32768, 0, 1, 0, 255);
        // neutral type ignores every axis
        add_row(CTRL_NEUTRAL, 0, 0, 256, 32767, -32768, 32767, -32768, 32767, 1, 0, 127);
        add_row(CTRL_NEUTRAL, 127, 0, 256, -32768, 32767, -32768, 32767, -32768, 1, 0, 0);
        add_row(CTRL_NEUTRAL, -128, 0, 256, 0, 0, 0, 0, 0, 1, 0, 255);
        // full-scale top speed, steering trimmed past both clamps
        add_row(CTRL_WHEEL, 127, 0, 65535, 32767, -32768, 32767, 0, 0, 1, 65535, 0);
        add_row(CTRL_WHEEL, 127, 0, 65535, -32768, 32767, -32768, 0, 0, 1, -65535, 128);
        add_row(CTRL_WHEEL, -128, 0, 65535, -32768, 0, 0, 0, 0, 1, 0, 255);
        // deadband covering the whole range gives zero speed both ways
        add_row(CTRL_WHEEL, 0, 127, 65535, 0, -32768, 32767, 0, 0, 1, 0, 127);
        add_row(CTRL_WHEEL, 0, 127, 65535, 0, 32767, -32768, 0, 0, 1, 0, 127);
        // widest usable deadband: only the last count survives, divisor of one
        add_row(CTRL_WHEEL, 0, 126, 65535, 0, -32768, 32767, 0, 0, 1, 65535, 127);
        add_row(CTRL_WHEEL, 0, 126, 65535, 0, 32767, -32768, 0, 0, 1, -65535, 127);
        add_row(CTRL_WHEEL, 0, 126, 65535, 0, 0, 512, 0, 0, 0, 0, 0);
        // zero top speed
        add_row(CTRL_WHEEL, 0, 0, 0, 0, -32768, 32767, 0, 0, 1, 0, 127);
        // mid-range values through a partial deadband
        add_row(CTRL_WHEEL, 5, 10, 1000, 1234, -5000, 20000, 0, 0, 0, 0, 0);
        add_row(CTRL_PAD_TRIG, -7, 10, 1000, 0, 0, 9000, -3000, -20000, 0, 0, 0);

        // reset held low at the start, then released once
        drive_cfg = make_cfg(CTRL_WHEEL, 0, 0, TOP_SPEED_RST);
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg != drive_cfg)
                apply_cfg(directed_rows[i].cfg);
            send_sample(directed_rows[i].ax,
                        directed_rows[i].typed ? directed_rows[i].want
                                               : predict_command(directed_rows[i].ax));
        end

        // random phases, each under its own register setting; the register
        // write waits for the pipeline to drain, so the sender pauses each time
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin db = 0;   off = -128; top = U16_MAX; end
                1: begin db = 126; off = 127;  top = $urandom_range(0, U16_MAX); end
                2: begin db = 127; off = $urandom_range(0, 255); top = U16_MAX; end
                3: begin db = $urandom_range(0, 20); off = 0; top = 0; end
                default:
                begin
                    db  = $urandom_range(0, 127);
                    off = $urandom_range(0, 255);
                    top = $urandom_range(0, U16_MAX);
                end
            endcase
            phase_cfg = make_cfg(ctrl_type_t'(p % 4), off, db, top);
            apply_cfg(phase_cfg);

            // backpressure from the output while the sender keeps offering
            if (p == 1)
                long_hold_req = 1'b1;
            // last phase runs with no idling on either side
            if (p == NUM_PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end

            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                ax.a0 = rand_axis();
                ax.a1 = rand_axis();
                ax.a2 = rand_axis();
                ax.a3 = rand_axis();
                ax.a5 = rand_axis();
                send_sample(ax, predict_command(ax));
            end
        end

        // drain, then give stray transfers a chance to show up
        wait_idle();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
